// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; they expand to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed in the same cycle");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed in the next cycle");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ksmt_pkg.sv =====
// Shared widths, types and helpers of the multiplication-table rank search.
package ksmt_pkg;
	localparam int SIDE_W = 20;
	localparam int RANK_W = 39;
	localparam int PROD_W = 40;
	localparam logic [SIDE_W-1:0] MAX_SIDE = 20'd524288;

	typedef struct packed {
		logic load;
		logic setup;
		logic round;
		logic step;
		logic decide;
		logic emit;
	} ksmt_cmd_t;

	typedef struct packed {
		logic walk_done;
		logic search_open;
		logic count_ge;
	} ksmt_sts_t;

	function automatic logic [SIDE_W-1:0] side_clamp(input logic [SIDE_W-1:0] s);
		logic [SIDE_W-1:0] r;
		r = s;
		if (s == '0) begin
			r = SIDE_W'(1);
		end else if (s > MAX_SIDE) begin
			r = MAX_SIDE;
		end
		return r;
	endfunction
endpackage

// ===== rtl/ksmt_dp.sv =====
// Datapath: query registers, search bounds, staircase counting walk, result register.
module ksmt_dp import ksmt_pkg::*; (
	input  logic              clk,
	input  logic [SIDE_W-1:0] rows,
	input  logic [SIDE_W-1:0] cols,
	input  logic [RANK_W-1:0] rank,
	input  ksmt_cmd_t         cmd,
	output ksmt_sts_t         sts,
	output logic [RANK_W-1:0] value
);
	logic [SIDE_W-1:0]   nr_q, nc_q, i_q, j_q;
	logic [RANK_W-1:0]   want_q, lo_q, hi_q, mid_q, total_q, value_q;
	logic [PROD_W-1:0]   p_q;
	logic [2*SIDE_W-1:0] prod;
	logic                over;

	assign prod = (2*SIDE_W)'(nr_q) * (2*SIDE_W)'(nc_q);
	// i*j above the candidate: step the column back
	assign over = p_q > {1'b0, mid_q};

	assign sts.count_ge    = total_q >= want_q;
	assign sts.walk_done   = (i_q > nr_q) || (j_q == '0) || sts.count_ge;
	assign sts.search_open = hi_q > lo_q;
	assign value           = value_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			nr_q   <= side_clamp(rows);
			nc_q   <= side_clamp(cols);
			want_q <= rank;
		end
		if (cmd.setup) begin
			lo_q <= RANK_W'(1);
			hi_q <= RANK_W'(prod);
		end
		if (cmd.round) begin
			mid_q   <= lo_q + ((hi_q - lo_q) >> 1);
			i_q     <= SIDE_W'(1);
			j_q     <= nc_q;
			p_q     <= PROD_W'(nc_q);
			total_q <= '0;
		end
		if (cmd.step) begin
			if (over) begin
				j_q <= j_q - SIDE_W'(1);
				p_q <= p_q - PROD_W'(i_q);
			end else begin
				total_q <= total_q + RANK_W'(j_q);
				i_q     <= i_q + SIDE_W'(1);
				p_q     <= p_q + PROD_W'(j_q);
			end
		end
		if (cmd.decide) begin
			if (sts.count_ge) begin
				hi_q <= mid_q;
			end else begin
				lo_q <= mid_q + RANK_W'(1);
			end
		end
		if (cmd.emit) begin
			value_q <= lo_q;
		end
	end
endmodule

// ===== rtl/ksmt_ctrl.sv =====
// Controller: sequences setup, search rounds and counting walk; owns both handshakes.
module ksmt_ctrl import ksmt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  ksmt_sts_t sts,
	output ksmt_cmd_t cmd
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SETUP  = 3'd1;
	localparam logic [2:0] S_CHECK  = 3'd2;
	localparam logic [2:0] S_ROUND  = 3'd3;
	localparam logic [2:0] S_WALK   = 3'd4;
	localparam logic [2:0] S_DECIDE = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SETUP;
				end
			end
			S_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = S_CHECK;
			end
			S_CHECK: begin
				state_d = sts.search_open ? S_ROUND : S_EMIT;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				state_d   = S_WALK;
			end
			S_WALK: begin
				if (sts.walk_done) begin
					state_d = S_DECIDE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = S_CHECK;
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			priority if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== rtl/kth_smallest_mult_table.sv =====
// Top level of the multiplication-table rank search block.
//
// Usage: a query (rows, cols, rank) transfers on the input channel when
// in_valid and in_ready are both high; one result (value) transfers on the
// output channel when out_valid and out_ready are both high. value is the
// rank-th smallest entry of the rows-by-cols multiplication table. Sides of
// zero count as one, sides above MAX_SIDE count as MAX_SIDE, and a rank
// beyond the table gives rows*cols.
// The block binary-searches the value range 1..rows*cols. Each round counts
// the entries not above the candidate with a staircase walk over the table:
// each step either moves down a row or steps back a column, and the walk
// stops early once the count reaches the rank. A query runs at most R rounds,
// where R <= ceil(log2(rows*cols)) <= 38; the walk sets the rate.
// One query is in flight at a time; in_ready rises again as soon as the
// result moves to the output register, so a new query may transfer while
// the previous result still waits for the receiver.
// A stalled receiver holds the result and valid; the block finishes its
// next search and then waits until the output register frees up.
// Reset (arst_n low) drops any query in flight and any held result.
module kth_smallest_mult_table import ksmt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SIDE_W-1:0] rows,
	input  logic [SIDE_W-1:0] cols,
	input  logic [RANK_W-1:0] rank,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [RANK_W-1:0] value
);
	`include "assert_macros.svh"

	ksmt_cmd_t cmd;
	ksmt_sts_t sts;

	// Sequence the search and own both handshakes
	ksmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold the query, bounds, walk counters and result register
	ksmt_dp u_dp (
		.clk   (clk),
		.rows  (rows),
		.cols  (cols),
		.rank  (rank),
		.cmd   (cmd),
		.sts   (sts),
		.value (value)
	);

	// A transfer in makes the block busy at once
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	// Never overwrite a result the receiver has not taken
	`ASSERT_SAME(a_emit_into_free, clk, arst_n, cmd.emit, !out_valid || out_ready)
	// The lower bound starts at one, so every result is at least one
	`ASSERT_SAME(a_value_nonzero, clk, arst_n, out_valid, value != '0)
endmodule
